/* rtl/hash_table_triangular_probe_core_macros.svh */
// Assertion macros used by the checker of the hash table core.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef HASH_TABLE_TRIANGULAR_PROBE_CORE_MACROS_SVH
`define HASH_TABLE_TRIANGULAR_PROBE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HTP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define HTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/htp_pkg.sv */
// Package of the triangular-probe hash table: payload structs, codes, helpers.
// Depends on nothing; used by the core and its checker.
package htp_pkg;

    localparam int DATA_W    = 64;
    localparam int LEN_W     = 4;
    localparam int COUNT_W   = 11;
    localparam int LIMIT_W   = 10;
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 10'd512;

    typedef enum logic [1:0] {
        MODE_FIND = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_REPLACED  = 3'd3,
        ST_UNCHANGED = 3'd4,
        ST_INVALID   = 3'd5,
        ST_FULL      = 3'd6,
        ST_DELETED   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DATA_W-1:0] key_hash;
        logic [LEN_W-1:0]  key_len;
        logic [DATA_W-1:0] key_bytes;
        logic [LEN_W-1:0]  value_len;
        logic [DATA_W-1:0] value_bytes;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  found_value;
        logic [LEN_W-1:0]   found_value_len;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    // Keep the low n bytes of a 64-bit word.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (LEN_W'(i) < n)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

/* rtl/hash_table_triangular_probe_core.sv */
// Open-addressing hash table with triangular probing, one request at a time.
// Depends on htp_pkg.
//
// Usage
//   Requests arrive on req (req_valid/req_ready); each gives exactly one result
//   on rsp (rsp_valid/rsp_ready). A transfer happens on a rising edge with
//   valid and ready both high. load_limit is written through cfg_we/cfg_wdata;
//   the user must write it only while the block is idle; the core does not enforce it.
//   Reset: control state clears at once, then a clearing pass marks every slot
//   empty, one slot a cycle, with req_ready low until the pass ends.
//   A request answered without probing (invalid key, empty key, unused mode)
//   goes straight to its result. When TABLE_DEPTH is not a power of two, the
//   home slot is first reduced bit-serially: hash modulo TABLE_DEPTH, most
//   significant bit first.
//   A new request is taken only after the last one's result has been loaded
//   into the output register; each probe is a read of the slot memories (S_READ)
//   and then a compare (S_CHECK); probes, reduction and output stalls set the rate.
//   Stall: the result waits in the output register while rsp_ready is low;
//   the next request may still be taken and worked on, and its result is
//   held back until the output register frees.
module hash_table_triangular_probe_core
    import htp_pkg::*;
#(
    parameter int TABLE_DEPTH     = 1024,
    parameter int MAX_FIELD_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    localparam int AW   = $clog2(TABLE_DEPTH);          // slot index
    localparam int TW   = $clog2(TABLE_DEPTH + 1);      // probe and slot counts
    localparam int SW   = TW + 1;                       // probe step sum
    localparam int RW   = AW + 1;                       // reduction remainder
    localparam int CMPW = (TW > LIMIT_W) ? TW : LIMIT_W;
    localparam int KB   = 8 * MAX_FIELD_BYTES;          // stored key and value bits
    localparam bit DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [AW-1:0]    LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [TW-1:0]    DEPTH_T   = TW'(TABLE_DEPTH);
    localparam logic [SW-1:0]    DEPTH_S   = SW'(TABLE_DEPTH);
    localparam logic [RW-1:0]    DEPTH_R   = RW'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_FIELD_BYTES);

    // Slot memories: tags are cleared after reset, contents are not.
    tag_t             tag_mem  [TABLE_DEPTH];
    logic [DATA_W-1:0] hash_mem [TABLE_DEPTH];
    logic [KB-1:0]    key_mem  [TABLE_DEPTH];
    logic [LEN_W-1:0] klen_mem [TABLE_DEPTH];
    logic [KB-1:0]    val_mem  [TABLE_DEPTH];
    logic [LEN_W-1:0] vlen_mem [TABLE_DEPTH];

    // Control registers
    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [TW-1:0]      probe_reg, probe_next;
    logic [AW-1:0]      rem_reg, rem_next;
    logic [5:0]         bit_reg, bit_next;
    logic [TW-1:0]      used_reg, used_next;
    logic [TW-1:0]      live_reg, live_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               rsp_valid_reg, rsp_valid_next;

    // Request and result payload registers
    logic [1:0]        mode_reg, mode_next;
    logic [DATA_W-1:0] hash_reg, hash_next;
    logic [LEN_W-1:0]  klen_reg, klen_next;
    logic [KB-1:0]     key_reg, key_next;
    logic [LEN_W-1:0]  vlen_reg, vlen_next;
    logic [KB-1:0]     val_reg, val_next;
    status_t           res_status_reg, res_status_next;
    logic [KB-1:0]     res_fval_reg, res_fval_next;
    logic [LEN_W-1:0]  res_fvlen_reg, res_fvlen_next;
    rsp_t              rsp_reg, rsp_next;

    // Memory read data
    tag_t              tag_rd_reg;
    logic [DATA_W-1:0] hash_rd_reg;
    logic [KB-1:0]     key_rd_reg;
    logic [LEN_W-1:0]  klen_rd_reg;
    logic [KB-1:0]     val_rd_reg;
    logic [LEN_W-1:0]  vlen_rd_reg;

    // Memory write controls
    logic          tag_we;
    tag_t          tag_wdata;
    logic [AW-1:0] tag_waddr;
    logic          ent_we;
    logic          val_we;

    // Shared datapath terms
    logic [SW-1:0] step_sum;
    logic [SW-1:0] step_mod;
    logic [TW-1:0] probe_inc;
    logic [RW-1:0] red_sum;
    logic [RW-1:0] red_mod;
    logic          slot_hit;
    logic          slot_empty;
    logic          used_below;
    logic          same_value;
    logic [LEN_W-1:0] vlen_sat;

    // Next triangular offset: idx + probe + 1 stays below twice the depth.
    assign step_sum  = SW'(idx_reg) + SW'(probe_reg) + SW'(1);
    assign step_mod  = (step_sum >= DEPTH_S) ? step_sum - DEPTH_S : step_sum;
    assign probe_inc = probe_reg + TW'(1);

    // One bit of hash modulo depth, most significant bit first.
    assign red_sum = {rem_reg, hash_reg[~bit_reg]};
    assign red_mod = (red_sum >= DEPTH_R) ? red_sum - DEPTH_R : red_sum;

    assign slot_empty = tag_rd_reg == TAG_EMPTY;
    assign slot_hit   = (tag_rd_reg == TAG_LIVE) && (hash_rd_reg == hash_reg)
                     && (klen_rd_reg == klen_reg) && (key_rd_reg == key_reg);
    assign same_value = (vlen_rd_reg == vlen_reg) && (val_rd_reg == val_reg);
    assign used_below = CMPW'(used_reg) < CMPW'(limit_reg);
    assign vlen_sat   = (req.value_len > MAX_LEN) ? MAX_LEN : req.value_len;

    assign tag_waddr = (state_reg == S_CLEAR) ? clr_reg : idx_reg;

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer: next state, datapath steering and memory writes.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        used_next       = used_reg;
        live_next       = live_reg;
        mode_next       = mode_reg;
        hash_next       = hash_reg;
        klen_next       = klen_reg;
        key_next        = key_reg;
        vlen_next       = vlen_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_fval_next   = res_fval_reg;
        res_fvlen_next  = res_fvlen_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        tag_we          = 1'b0;
        tag_wdata       = TAG_EMPTY;
        ent_we          = 1'b0;
        val_we          = 1'b0;

        // Drop the result once the receiver takes it.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                tag_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next       = req.mode;
                    hash_next       = req.key_hash;
                    klen_next       = req.key_len;
                    key_next        = KB'(req.key_bytes & byte_mask(req.key_len));
                    vlen_next       = vlen_sat;
                    val_next        = KB'(req.value_bytes & byte_mask(vlen_sat));
                    res_fval_next   = '0;
                    res_fvlen_next  = '0;
                    probe_next      = '0;
                    rem_next        = '0;
                    bit_next        = '0;
                    idx_next        = req.key_hash[AW-1:0];
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                    if (req.mode != MODE_FIND && req.mode != MODE_ADD
                        && req.mode != MODE_DEL)
                    begin
                        res_status_next = ST_MISS;
                    end
                    else if (req.key_len > MAX_LEN
                             || (req.key_len == '0 && req.mode == MODE_ADD))
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else if (req.key_len == '0)
                    begin
                        res_status_next = ST_MISS;
                    end
                    else if (DEPTH_POW2)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_REDUCE;
                    end
                end
            end

            S_REDUCE:
            begin
                rem_next = red_mod[AW-1:0];
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd63)
                begin
                    idx_next   = red_mod[AW-1:0];
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (slot_empty || slot_hit || probe_inc == DEPTH_T)
                begin
                    state_next = S_DONE;
                    case (mode_reg)
                        MODE_FIND:
                        begin
                            if (slot_hit)
                            begin
                                res_status_next = ST_HIT;
                                res_fval_next   = val_rd_reg;
                                res_fvlen_next  = vlen_rd_reg;
                            end
                            else
                            begin
                                res_status_next = ST_MISS;
                            end
                        end

                        MODE_DEL:
                        begin
                            if (slot_hit)
                            begin
                                tag_we          = 1'b1;
                                tag_wdata       = TAG_TOMB;
                                res_status_next = ST_DELETED;
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - TW'(1);
                                end
                            end
                            else
                            begin
                                res_status_next = ST_MISS;
                            end
                        end

                        MODE_ADD:
                        begin
                            if (slot_hit)
                            begin
                                if (vlen_reg == '0 || same_value)
                                begin
                                    res_status_next = ST_UNCHANGED;
                                end
                                else
                                begin
                                    val_we          = 1'b1;
                                    res_status_next = ST_REPLACED;
                                end
                            end
                            else if (slot_empty && used_below)
                            begin
                                tag_we          = 1'b1;
                                tag_wdata       = TAG_LIVE;
                                ent_we          = 1'b1;
                                used_next       = used_reg + TW'(1);
                                live_next       = live_reg + TW'(1);
                                res_status_next = ST_INSERTED;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end

                        default:
                        begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
                else
                begin
                    idx_next   = step_mod[AW-1:0];
                    probe_next = probe_inc;
                    state_next = S_READ;
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register frees.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status          = res_status_reg;
                    rsp_next.found_value     = DATA_W'(res_fval_reg);
                    rsp_next.found_value_len = res_fvlen_reg;
                    rsp_next.entry_count     = COUNT_W'(live_reg);
                    rsp_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, set by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            probe_reg     <= '0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            used_reg      <= '0;
            live_reg      <= '0;
            limit_reg     <= LOAD_LIMIT_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            rem_reg       <= rem_next;
            bit_reg       <= bit_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        hash_reg       <= hash_next;
        klen_reg       <= klen_next;
        key_reg        <= key_next;
        vlen_reg       <= vlen_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_fval_reg   <= res_fval_next;
        res_fvlen_reg  <= res_fvlen_next;
        rsp_reg        <= rsp_next;
    end

    // Slot memories: one write and one registered read per cycle at idx or clr_reg.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (ent_we)
        begin
            hash_mem[idx_reg] <= hash_reg;
            key_mem[idx_reg]  <= key_reg;
            klen_mem[idx_reg] <= klen_reg;
        end
        if (ent_we || val_we)
        begin
            val_mem[idx_reg]  <= val_reg;
            vlen_mem[idx_reg] <= vlen_reg;
        end
        tag_rd_reg  <= tag_mem[idx_reg];
        hash_rd_reg <= hash_mem[idx_reg];
        key_rd_reg  <= key_mem[idx_reg];
        klen_rd_reg <= klen_mem[idx_reg];
        val_rd_reg  <= val_mem[idx_reg];
        vlen_rd_reg <= vlen_mem[idx_reg];
    end

endmodule

/* rtl/htp_chk.sv */
// Port-level checker for the hash table core, attached by bind.
// Depends on htp_pkg and hash_table_triangular_probe_core_macros.svh.
`include "hash_table_triangular_probe_core_macros.svh"

module htp_chk
    import htp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input req_t               req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input rsp_t               rsp,
    input logic               cfg_we,
    input logic [LIMIT_W-1:0] cfg_wdata
);

    // A stalled result holds.
    `HTP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

    // The block works on one request at a time.
    `HTP_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")

    // Only a hit carries a value.
    `HTP_ASSERT_SAME(a_miss_no_value, rsp_valid && rsp.status != ST_HIT, rsp.found_value == '0 && rsp.found_value_len == '0, "value returned without a hit")

    // An insert leaves at least one live entry.
    `HTP_ASSERT_SAME(a_insert_count, rsp_valid && rsp.status == ST_INSERTED, rsp.entry_count != '0, "insert with zero live entries")

endmodule

bind hash_table_triangular_probe_core htp_chk u_htp_chk (.*);

/* tb/sv/hash_table_triangular_probe_core_test.sv */
// Self-checking testbench for hash_table_triangular_probe_core: a directed table and random
// phases, each result checked against a shadow copy of the slot store or a fixed result.
// Depends on htp_pkg and the core RTL only.
`timescale 1ns / 100ps

module hash_table_triangular_probe_core_test;
    import htp_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int MAX_BYTES    = 8;
    localparam int POOL_MAX     = 400;
    localparam int HOLD_CYCLES  = 500;
    localparam int CFG_SETTLE   = 4;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int NUM_PHASES   = 5;

    // The one mode value the package leaves unnamed; the block must answer miss.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [63:0] H_TOP = 64'hFFFF_FFFF_FFFF_FFFF; // home slot 1023
    localparam logic [63:0] H_COL = 64'h0000_0000_0000_03FF; // same home, other hash
    localparam logic [63:0] KEY_A = 64'hA5A5_5A5A_0F0F_F0F0;
    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        req_t               r;
        bit                 typed;
        rsp_t               want;
        logic [LIMIT_W-1:0] limit;
    } dir_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] hash;
        logic [DATA_W-1:0] key;
        logic [LEN_W-1:0]  klen;
    } key_rec_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;

    // Shadow of the slot store and counters
    tag_t               sh_tag   [DEPTH];
    logic [DATA_W-1:0]  sh_hash  [DEPTH];
    logic [DATA_W-1:0]  sh_key   [DEPTH];
    logic [LEN_W-1:0]   sh_klen  [DEPTH];
    logic [DATA_W-1:0]  sh_value [DEPTH];
    logic [LEN_W-1:0]   sh_vlen  [DEPTH];
    logic [COUNT_W-1:0] sh_used;
    logic [COUNT_W-1:0] sh_live;
    logic [LIMIT_W-1:0] sh_limit;

    rsp_t     expected_rsp [$];
    key_rec_t key_pool [$];
    dir_row_t dir_rows [$];

    bit sender_gaps_on = 1'b1;
    bit stalls_on      = 1'b1;
    bit hold_request   = 1'b0;

    int mismatches    = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int limit_writes  = 0;
    int longest_hold  = 0;
    int cycle_count   = 0;
    int status_seen [8];

    hash_table_triangular_probe_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------

    // Low n bytes of a word; anything from eight up keeps the whole word.
    function automatic logic [DATA_W-1:0] keep_bytes(input logic [LEN_W-1:0] n);
        return (n >= LEN_W'(MAX_BYTES)) ? ONES : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // Walk the triangular probe chain: home, +1, +3, +6, ... Stop at the first
    // empty slot or at a live slot holding the same hash, length and key bytes.
    // Tombstones are stepped over.
    function automatic void probe_chain(input logic [DATA_W-1:0] h,
                                        input logic [DATA_W-1:0] k,
                                        input logic [LEN_W-1:0] kl,
                                        output logic [IDX_W-1:0] idx,
                                        output bit hit, output bit hole);
        idx  = h[IDX_W-1:0];
        hit  = 1'b0;
        hole = 1'b0;
        for (int t = 0; t < DEPTH; t++)
        begin
            if (sh_tag[idx] == TAG_EMPTY)
            begin
                hole = 1'b1;
                break;
            end
            if (sh_tag[idx] == TAG_LIVE && sh_hash[idx] == h && sh_klen[idx] == kl
                && sh_key[idx] == k)
            begin
                hit = 1'b1;
                break;
            end
            idx = idx + IDX_W'(t + 1);
        end
    endfunction

    // Apply one request to the shadow table and return the result it must give.
    function automatic rsp_t apply_to_shadow_table(input req_t r);
        rsp_t             o;
        logic [LEN_W-1:0] vl;
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;
        logic [IDX_W-1:0] idx;
        bit               hit;
        bit               hole;
        o                 = '0;
        o.status          = ST_MISS;
        vl = (r.value_len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : r.value_len;
        k  = r.key_bytes & keep_bytes(r.key_len);
        v  = r.value_bytes & keep_bytes(vl);
        if (r.mode == MODE_UNUSED)
        begin
            o.status = ST_MISS;
        end
        else if (r.key_len > LEN_W'(MAX_BYTES) || (r.key_len == '0 && r.mode == MODE_ADD))
        begin
            o.status = ST_INVALID;
        end
        else if (r.key_len != '0)
        begin
            probe_chain(r.key_hash, k, r.key_len, idx, hit, hole);
            if (r.mode == MODE_FIND)
            begin
                if (hit)
                begin
                    o.status          = ST_HIT;
                    o.found_value     = sh_value[idx];
                    o.found_value_len = sh_vlen[idx];
                end
            end
            else if (r.mode == MODE_DEL)
            begin
                if (hit)
                begin
                    sh_tag[idx] = TAG_TOMB;
                    if (sh_live != '0)
                        sh_live = sh_live - 1'b1;
                    o.status = ST_DELETED;
                end
            end
            else if (hit)
            begin
                // Replacement ignores the load limit
                if (vl == '0 || (sh_vlen[idx] == vl && sh_value[idx] == v))
                begin
                    o.status = ST_UNCHANGED;
                end
                else
                begin
                    sh_value[idx] = v;
                    sh_vlen[idx]  = vl;
                    o.status      = ST_REPLACED;
                end
            end
            else if (hole && sh_used < COUNT_W'(sh_limit))
            begin
                sh_tag[idx]   = TAG_LIVE;
                sh_hash[idx]  = r.key_hash;
                sh_key[idx]   = k;
                sh_klen[idx]  = r.key_len;
                sh_value[idx] = v;
                sh_vlen[idx]  = vl;
                sh_used       = sh_used + 1'b1;
                sh_live       = sh_live + 1'b1;
                o.status      = ST_INSERTED;
            end
            else
            begin
                o.status = ST_FULL;
            end
        end
        o.entry_count = sh_live;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle stretch: mostly none or short, now and then long.
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 90);
    endfunction

    function automatic req_t req_of(input logic [1:0] m, input logic [DATA_W-1:0] h,
                                    input logic [LEN_W-1:0] kl, input logic [DATA_W-1:0] k,
                                    input logic [LEN_W-1:0] vl, input logic [DATA_W-1:0] v);
        req_t r;
        r.mode        = m;
        r.key_hash    = h;
        r.key_len     = kl;
        r.key_bytes   = k;
        r.value_len   = vl;
        r.value_bytes = v;
        return r;
    endfunction

    function automatic rsp_t rsp_of(input status_t st, input logic [DATA_W-1:0] fv,
                                    input logic [LEN_W-1:0] fl, input logic [COUNT_W-1:0] n);
        rsp_t o;
        o.status          = st;
        o.found_value     = fv;
        o.found_value_len = fl;
        o.entry_count     = n;
        return o;
    endfunction

    task automatic add_row(input req_t r, input bit typed, input rsp_t want);
        dir_rows.push_back('{ROW_REQ, r, typed, want, '0});
    endtask

    // Random request. Most reuse keys already seen so that hits, replaces and
    // deletes happen; new keys often share a few hot home slots to build long
    // chains; a small share is noise over every field value.
    function automatic req_t gen_item();
        req_t             r;
        key_rec_t         kr;
        logic [IDX_W-1:0] idx;
        bit               hit;
        bit               hole;
        int               roll;
        int               b;
        r             = '0;
        r.mode        = MODE_ADD;
        r.key_hash    = {$urandom, $urandom};
        r.key_bytes   = {$urandom, $urandom};
        r.value_bytes = {$urandom, $urandom};
        r.key_len     = LEN_W'($urandom_range(1, MAX_BYTES));
        roll          = $urandom_range(0, 9);
        r.value_len   = (roll == 0) ? '0 :
                        (roll == 1) ? LEN_W'($urandom_range(MAX_BYTES + 1, 15)) :
                                      LEN_W'($urandom_range(1, MAX_BYTES));
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            r.mode    = 2'($urandom_range(0, 3));
            r.key_len = LEN_W'($urandom_range(0, 15));
        end
        else if (roll < 62 && key_pool.size() > 0)
        begin
            kr          = key_pool[$urandom_range(0, key_pool.size() - 1)];
            r.key_hash  = kr.hash;
            r.key_len   = kr.klen;
            r.key_bytes = kr.key | (r.key_bytes & ~keep_bytes(kr.klen));
            roll        = $urandom_range(0, 99);
            r.mode      = (roll < 40) ? MODE_FIND : (roll < 78) ? MODE_ADD : MODE_DEL;
            // Near misses: one hash bit off, or the same bytes under another length
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    b             = $urandom_range(0, DATA_W - 1);
                    r.key_hash[b] = ~r.key_hash[b];
                end
                else
                begin
                    r.key_len = (kr.klen == LEN_W'(MAX_BYTES)) ? kr.klen - 1'b1 : kr.klen + 1'b1;
                end
            end
            // Offer the stored value again now and then
            if (r.mode == MODE_ADD && $urandom_range(0, 3) == 0)
            begin
                probe_chain(r.key_hash, r.key_bytes & keep_bytes(r.key_len), r.key_len,
                            idx, hit, hole);
                if (hit)
                begin
                    r.value_len   = sh_vlen[idx];
                    r.value_bytes = sh_value[idx] | (r.value_bytes & ~keep_bytes(sh_vlen[idx]));
                end
            end
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15 && key_pool.size() > 0)
                r.key_hash = key_pool[$urandom_range(0, key_pool.size() - 1)].hash;
            else if (roll < 55)
                r.key_hash[IDX_W-1:0] = IDX_W'($urandom_range(0, 15) * 67 + 1015);
            roll   = $urandom_range(0, 9);
            r.mode = (roll < 8) ? MODE_ADD : (roll == 8) ? MODE_FIND : MODE_DEL;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until its transfer, then record what must come back.
    task automatic issue(input req_t r, input bit typed, input rsp_t want);
        int       gap;
        rsp_t     model;
        key_rec_t kr;
        gap = sender_gaps_on ? idle_span() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        model = apply_to_shadow_table(r);
        expected_rsp.push_back(typed ? want : model);
        if (model.status == ST_INSERTED)
        begin
            kr.hash = r.key_hash;
            kr.key  = r.key_bytes & keep_bytes(r.key_len);
            kr.klen = r.key_len;
            if (key_pool.size() < POOL_MAX)
                key_pool.push_back(kr);
            else
                key_pool[$urandom_range(0, POOL_MAX - 1)] = kr;
        end
        items_sent++;
    endtask

    // Write load_limit once the block has drained. Called at the edge of the
    // last transfer, so dropping valid here is the only assignment this step.
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sh_limit = v;
        limit_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each transfer, then pick the next ready level
    // ------------------------------------------------------------------
    initial
    begin : rsp_side
        rsp_t want;
        int   stall_left;
        int   hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && rsp_ready)
            begin
                results_seen++;
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with nothing outstanding: status %0d count %0d",
                                 $realtime, rsp.status, rsp.entry_count);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    status_seen[int'(want.status)]++;
                    if (rsp.status !== want.status || rsp.found_value !== want.found_value
                        || rsp.found_value_len !== want.found_value_len
                        || rsp.entry_count !== want.entry_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] result %0d mismatch: status %0d/%0d value %h/%h",
                                      " len %0d/%0d count %0d/%0d (expected/actual)"},
                                     $realtime, results_seen, want.status, rsp.status,
                                     want.found_value, rsp.found_value,
                                     want.found_value_len, rsp.found_value_len,
                                     want.entry_count, rsp.entry_count);
                    end
                end
            end

            // Flip between stalling and free-running stretches now and then
            if ($urandom_range(0, 63) == 0)
                stalls_on = !stalls_on;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                longest_hold = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 99) < 25)
                    stall_left = idle_span();
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_rsp.size());
        $display("hash_table_triangular_probe_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int phase_limit [NUM_PHASES];
        int phase_items [NUM_PHASES];

        for (int i = 0; i < DEPTH; i++)
        begin
            sh_tag[i]   = TAG_EMPTY;
            sh_hash[i]  = '0;
            sh_key[i]   = '0;
            sh_klen[i]  = '0;
            sh_value[i] = '0;
            sh_vlen[i]  = '0;
        end
        sh_used  = '0;
        sh_live  = '0;
        sh_limit = LOAD_LIMIT_RST;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed table. Runs under the reset load limit until the write row.
        // Empty table, then the invalid and unused-mode answers.
        add_row(req_of(MODE_FIND, H_TOP, 4'd8, KEY_A, 4'd0, '0), 1,
                rsp_of(ST_MISS, '0, '0, 11'd0));
        add_row(req_of(MODE_ADD, H_TOP, 4'd0, KEY_A, 4'd8, ONES), 1,
                rsp_of(ST_INVALID, '0, '0, 11'd0));
        add_row(req_of(MODE_FIND, H_TOP, 4'd0, '0, 4'd0, '0), 1,
                rsp_of(ST_MISS, '0, '0, 11'd0));
        add_row(req_of(MODE_DEL, '0, 4'd0, ONES, 4'd0, '0), 1,
                rsp_of(ST_MISS, '0, '0, 11'd0));
        add_row(req_of(MODE_ADD, H_TOP, 4'd9, KEY_A, 4'd8, ONES), 1,
                rsp_of(ST_INVALID, '0, '0, 11'd0));
        add_row(req_of(MODE_FIND, ONES, 4'd15, ONES, 4'd15, ONES), 1,
                rsp_of(ST_INVALID, '0, '0, 11'd0));
        add_row(req_of(MODE_UNUSED, H_TOP, 4'd8, KEY_A, 4'd8, ONES), 1,
                rsp_of(ST_MISS, '0, '0, 11'd0));
        // Insert, find, and the unchanged and replace answers
        add_row(req_of(MODE_ADD, H_TOP, 4'd8, KEY_A, 4'd8, ONES), 1,
                rsp_of(ST_INSERTED, '0, '0, 11'd1));
        add_row(req_of(MODE_FIND, H_TOP, 4'd8, KEY_A, 4'd0, '0), 1,
                rsp_of(ST_HIT, ONES, 4'd8, 11'd1));
        add_row(req_of(MODE_ADD, H_TOP, 4'd8, KEY_A, 4'd0, 64'h1234), 1,
                rsp_of(ST_UNCHANGED, '0, '0, 11'd1));
        add_row(req_of(MODE_ADD, H_TOP, 4'd8, KEY_A, 4'd15, ONES), 1,
                rsp_of(ST_UNCHANGED, '0, '0, 11'd1));
        add_row(req_of(MODE_ADD, H_TOP, 4'd8, KEY_A, 4'd1, 64'hDEAD_BEEF_0000_0012), 1,
                rsp_of(ST_REPLACED, '0, '0, 11'd1));
        add_row(req_of(MODE_FIND, H_TOP, 4'd8, KEY_A, 4'd0, '0), 1,
                rsp_of(ST_HIT, 64'h12, 4'd1, 11'd1));
        // Collision on the top slot wraps the chain round to slot 0
        add_row(req_of(MODE_ADD, H_COL, 4'd1, '0, 4'd0, ONES), 0, '0);
        add_row(req_of(MODE_FIND, H_COL, 4'd1, 64'hFF00, 4'd0, '0), 1,
                rsp_of(ST_HIT, '0, '0, 11'd2));
        add_row(req_of(MODE_FIND, H_COL, 4'd2, '0, 4'd0, '0), 1,
                rsp_of(ST_MISS, '0, '0, 11'd2));
        // Delete leaves a tombstone that find steps over and add does not reuse
        add_row(req_of(MODE_DEL, H_TOP, 4'd8, KEY_A, 4'd0, '0), 1,
                rsp_of(ST_DELETED, '0, '0, 11'd1));
        add_row(req_of(MODE_FIND, H_TOP, 4'd8, KEY_A, 4'd0, '0), 1,
                rsp_of(ST_MISS, '0, '0, 11'd1));
        add_row(req_of(MODE_FIND, H_COL, 4'd1, '0, 4'd0, '0), 1,
                rsp_of(ST_HIT, '0, '0, 11'd1));
        add_row(req_of(MODE_ADD, H_TOP, 4'd8, KEY_A, 4'd8, 64'h0123_4567_89AB_CDEF), 1,
                rsp_of(ST_INSERTED, '0, '0, 11'd2));
        add_row(req_of(MODE_DEL, H_COL, 4'd1, '0, 4'd0, '0), 1,
                rsp_of(ST_DELETED, '0, '0, 11'd1));
        add_row(req_of(MODE_DEL, H_COL, 4'd1, '0, 4'd0, '0), 1,
                rsp_of(ST_MISS, '0, '0, 11'd1));
        add_row(req_of(MODE_ADD, '0, 4'd8, ONES, 4'd8, 64'h8000_0000_0000_0000), 1,
                rsp_of(ST_INSERTED, '0, '0, 11'd2));
        // Four slots are now in use: lower the limit to that and try a new key
        dir_rows.push_back('{ROW_CFG, '0, 0, '0, LIMIT_W'(4)});
        add_row(req_of(MODE_ADD, 64'h5, 4'd1, 64'h55, 4'd1, 64'h77), 1,
                rsp_of(ST_FULL, '0, '0, 11'd2));
        add_row(req_of(MODE_ADD, '0, 4'd8, ONES, 4'd8, 64'h1), 1,
                rsp_of(ST_REPLACED, '0, '0, 11'd2));
        add_row(req_of(MODE_FIND, H_TOP, 4'd8, KEY_A, 4'd0, '0), 0, '0);

        // Load-limit settings for the random phases, lowest and highest among them
        phase_limit = '{1, 300, 1023, 0, 768};
        phase_limit[3] = $urandom_range(1, 1023);
        phase_items = '{150, 500, 600, 300, 376};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_limit(dir_rows[i].limit);
            else
                issue(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(LIMIT_W'(phase_limit[p]));
            for (int n = 0; n < phase_items[p]; n++)
            begin
                // Hold the result side off for a long stretch so the block stalls behind it
                if (p == 2 && n == 40)
                    hold_request = 1'b1;
                if ($urandom_range(0, 39) == 0)
                    sender_gaps_on = !sender_gaps_on;
                issue(gen_item(), 1'b0, '0);
            end
        end

        // Drop valid on the last transfer's edge, then drain
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests, %0d results, %0d limit writes, %0d-cycle hold-off",
                 items_sent, results_seen, limit_writes, longest_hold);
        $display({"statuses: hit %0d miss %0d inserted %0d replaced %0d unchanged %0d",
                  " invalid %0d full %0d deleted %0d; slots used %0d, mismatches %0d"},
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7],
                 sh_used, mismatches);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("hash_table_triangular_probe_core verification clean");
        else
            $display("hash_table_triangular_probe_core verification failed");
        $finish;
    end

endmodule
